// ===== hdl/lcdw_pkg.sv =====
// Shared types, codes and constants for the character LCD nibble writer.
// No dependencies; the decode, serializer and top files refer to it by scoped names.
package lcdw_pkg;

  // Default display geometry
  localparam int COLUMNS_DEFAULT = 20;
  localparam int ROWS_DEFAULT    = 4;

  // Display command codes
  typedef enum logic [2:0] {
    CMD_PUT       = 3'd0,
    CMD_CURSOR    = 3'd1,
    CMD_CLEAR     = 3'd2,
    CMD_HOME      = 3'd3,
    CMD_BACKLIGHT = 3'd4
  } lcdw_cmd_t;

  // Control characters handled by put
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // LCD instruction bytes
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] INSTR_CLEAR   = 8'h01;
  localparam logic [7:0] INSTR_HOME    = 8'h02;

  // Wait hints in milliseconds
  localparam logic [2:0] WAIT_NONE   = 3'd0;
  localparam logic [2:0] WAIT_STROBE = 3'd1;
  localparam logic [2:0] WAIT_DATA   = 3'd2;
  localparam logic [2:0] WAIT_CURSOR = 3'd3;
  localparam logic [2:0] WAIT_CLEAR  = 3'd5;

  // Three expander bytes per nibble
  typedef enum logic [1:0] {
    PH_PLAIN   = 2'd0,
    PH_EN_HIGH = 2'd1,
    PH_EN_LOW  = 2'd2
  } lcdw_phase_t;

  // Byte plan for one command: one or two LCD bytes, or a lone backlight byte
  typedef struct packed {
    logic       single;  // lone backlight byte, no nibbles
    logic       two;     // second LCD byte (cursor placement) follows
    logic [7:0] val0;
    logic       rs0;
    logic [2:0] wait0;   // wait on the final byte of the first LCD byte
    logic [7:0] val1;
    logic [2:0] wait1;
    logic       bl;
    logic [4:0] col;
    logic [1:0] row;
  } lcdw_plan_t;

  // DDRAM start address of each display line
  function automatic logic [7:0] line_start(input logic [1:0] row);
    logic [7:0] addr;
    case (row)
      2'd0:    addr = 8'h00;
      2'd1:    addr = 8'h40;
      2'd2:    addr = 8'h14;
      2'd3:    addr = 8'h54;
      default: addr = 8'h00;
    endcase
    return addr;
  endfunction

  // Set-DDRAM-address instruction for a cursor position
  function automatic logic [7:0] cursor_cmd(input logic [4:0] col, input logic [1:0] row);
    return LCD_SET_DDRAM | (line_start(row) + {3'b000, col});
  endfunction

endpackage

// ===== hdl/lcdw_cmd_if.sv =====
// Command channel of the LCD nibble writer: valid/ready plus command fields.
// No dependencies.
interface lcdw_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] char_code;
  logic [7:0] target_column;
  logic [7:0] target_row;
  logic       backlight_request;

  modport source (
    output valid, command, char_code, target_column, target_row, backlight_request,
    input  ready
  );
  modport sink (
    input  valid, command, char_code, target_column, target_row, backlight_request,
    output ready
  );
endinterface

// ===== hdl/lcdw_byte_if.sv =====
// Expander byte channel of the LCD nibble writer: valid/ready plus byte fields.
// No dependencies.
interface lcdw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] expander_byte;
  logic [2:0] wait_after_ms;
  logic       last;
  logic [4:0] column_now;
  logic [1:0] row_now;

  modport source (
    output valid, expander_byte, wait_after_ms, last, column_now, row_now,
    input  ready
  );
  modport sink (
    input  valid, expander_byte, wait_after_ms, last, column_now, row_now,
    output ready
  );
endinterface

// ===== hdl/lcdw_decode.sv =====
// Command decode: cursor and backlight state, and the byte plan register.
// Depends on lcdw_pkg and lcdw_cmd_if.
module lcdw_decode #(
  parameter int COLUMNS = lcdw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = lcdw_pkg::ROWS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  lcdw_cmd_if.sink            commands,
  output lcdw_pkg::lcdw_plan_t plan,
  output logic                plan_valid,
  input  logic                plan_take
);

  logic [4:0] cursor_column, cursor_column_next;
  logic [1:0] cursor_line, cursor_line_next;
  logic       backlight_lit, backlight_lit_next;

  lcdw_pkg::lcdw_plan_t plan_next;
  logic                 has_out;
  logic                 accept;
  logic [2:0]           line_inc;
  logic [1:0]           line_wrap;
  logic [4:0]           column_inc;
  logic [4:0]           clamp_col;
  logic [1:0]           clamp_row;

  // Take a command whenever the plan register is free or being emptied
  assign commands.ready = !plan_valid || plan_take;
  assign accept         = commands.valid && commands.ready;

  // Neighbor positions and clamped operands
  always_comb begin
    line_inc   = {1'b0, cursor_line} + 3'd1;
    line_wrap  = (line_inc >= 3'(ROWS)) ? 2'd0 : line_inc[1:0];
    column_inc = cursor_column + 5'd1;
    clamp_col  = (commands.target_column >= 8'(COLUMNS)) ? 5'(COLUMNS - 1)
                                                        : commands.target_column[4:0];
    clamp_row  = (commands.target_row >= 8'(ROWS)) ? 2'(ROWS - 1)
                                                  : commands.target_row[1:0];
  end

  // Decode the command into next state and a byte plan
  always_comb begin
    cursor_column_next = cursor_column;
    cursor_line_next   = cursor_line;
    backlight_lit_next = backlight_lit;
    has_out            = 1'b0;
    plan_next          = '0;
    plan_next.wait0    = lcdw_pkg::WAIT_CURSOR;
    plan_next.wait1    = lcdw_pkg::WAIT_CURSOR;
    case (lcdw_pkg::lcdw_cmd_t'(commands.command))
      lcdw_pkg::CMD_PUT: begin
        if (commands.char_code == lcdw_pkg::CH_NEWLINE) begin
          has_out            = 1'b1;
          cursor_column_next = 5'd0;
          cursor_line_next   = line_wrap;
        end else if (commands.char_code == lcdw_pkg::CH_RETURN) begin
          has_out            = 1'b1;
          cursor_column_next = 5'd0;
        end else if (commands.char_code == lcdw_pkg::CH_BACKSPACE) begin
          if (cursor_column != 5'd0) begin
            has_out            = 1'b1;
            cursor_column_next = cursor_column - 5'd1;
          end else if (cursor_line != 2'd0) begin
            has_out            = 1'b1;
            cursor_column_next = 5'(COLUMNS - 1);
            cursor_line_next   = cursor_line - 2'd1;
          end
        end else begin
          // Data byte, then wrap to the next line at the right edge
          has_out         = 1'b1;
          plan_next.rs0   = 1'b1;
          plan_next.wait0 = lcdw_pkg::WAIT_DATA;
          if (column_inc >= 5'(COLUMNS)) begin
            plan_next.two      = 1'b1;
            cursor_column_next = 5'd0;
            cursor_line_next   = line_wrap;
          end else begin
            cursor_column_next = column_inc;
          end
        end
        if (plan_next.rs0) begin
          plan_next.val0 = commands.char_code;
          plan_next.val1 = lcdw_pkg::cursor_cmd(cursor_column_next, cursor_line_next);
        end else begin
          plan_next.val0 = lcdw_pkg::cursor_cmd(cursor_column_next, cursor_line_next);
        end
      end
      lcdw_pkg::CMD_CURSOR: begin
        has_out            = 1'b1;
        cursor_column_next = clamp_col;
        cursor_line_next   = clamp_row;
        plan_next.val0     = lcdw_pkg::cursor_cmd(clamp_col, clamp_row);
      end
      lcdw_pkg::CMD_CLEAR, lcdw_pkg::CMD_HOME: begin
        has_out            = 1'b1;
        cursor_column_next = 5'd0;
        cursor_line_next   = 2'd0;
        plan_next.wait0    = lcdw_pkg::WAIT_CLEAR;
        plan_next.val0     = (commands.command == lcdw_pkg::CMD_CLEAR) ?
                             lcdw_pkg::INSTR_CLEAR : lcdw_pkg::INSTR_HOME;
      end
      lcdw_pkg::CMD_BACKLIGHT: begin
        has_out            = 1'b1;
        plan_next.single   = 1'b1;
        backlight_lit_next = commands.backlight_request;
      end
      default: begin
        has_out = 1'b0;
      end
    endcase
    plan_next.bl  = backlight_lit_next;
    plan_next.col = cursor_column_next;
    plan_next.row = cursor_line_next;
  end

  // Update cursor state and the plan valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= 5'd0;
      cursor_line   <= 2'd0;
      backlight_lit <= 1'b1;
      plan_valid    <= 1'b0;
    end else begin
      if (accept) begin
        cursor_column <= cursor_column_next;
        cursor_line   <= cursor_line_next;
        backlight_lit <= backlight_lit_next;
        plan_valid    <= has_out;
      end else if (plan_take) begin
        plan_valid <= 1'b0;
      end
    end
  end

  // Load the plan payload
  always_ff @(posedge clk) begin
    if (accept) begin
      plan <= plan_next;
    end
  end

  // A waiting plan holds until the serializer takes it
  assert property (@(posedge clk) disable iff (rst)
    plan_valid && !plan_take |=> plan_valid && $stable(plan))
    else $error("plan changed before it was taken");

  // The cursor never leaves the display
  assert property (@(posedge clk) disable iff (rst)
    (cursor_column < 5'(COLUMNS)) && ({1'b0, cursor_line} < 3'(ROWS)))
    else $error("cursor out of range");

  // Unused command codes leave no plan behind
  assert property (@(posedge clk) disable iff (rst)
    accept && (commands.command > lcdw_pkg::CMD_BACKLIGHT) |=> !plan_valid)
    else $error("unused command produced bytes");

endmodule

// ===== hdl/lcdw_serializer.sv =====
// Byte serializer: walks a plan out as expander bytes, three per nibble.
// Depends on lcdw_pkg and lcdw_byte_if.
module lcdw_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  lcdw_pkg::lcdw_plan_t plan_in,
  input  logic                 plan_valid,
  output logic                 plan_take,
  lcdw_byte_if.source          expander
);

  lcdw_pkg::lcdw_plan_t  plan;
  logic                  busy;
  logic                  sel;    // which LCD byte of the plan
  logic                  nib;    // 0 high nibble, 1 low nibble
  lcdw_pkg::lcdw_phase_t phase;

  logic       fire;
  logic       is_last;
  logic [7:0] cur_val;
  logic       cur_rs;
  logic [2:0] cur_wait;
  logic [3:0] nibble;

  assign fire      = expander.valid && expander.ready;
  assign plan_take = plan_valid && (!busy || (fire && is_last));

  // Build the current expander byte: nibble, backlight, EN, 0, RS
  always_comb begin
    cur_val  = sel ? plan.val1 : plan.val0;
    cur_rs   = sel ? 1'b0 : plan.rs0;
    cur_wait = sel ? plan.wait1 : plan.wait0;
    nibble   = nib ? cur_val[3:0] : cur_val[7:4];
    is_last  = plan.single || ((phase == lcdw_pkg::PH_EN_LOW) && nib && (sel || !plan.two));
    if (plan.single) begin
      expander.expander_byte = {4'b0000, plan.bl, 3'b000};
      expander.wait_after_ms = lcdw_pkg::WAIT_NONE;
    end else begin
      case (phase)
        lcdw_pkg::PH_EN_HIGH: begin
          expander.expander_byte = {nibble, plan.bl, 1'b1, 1'b0, cur_rs};
          expander.wait_after_ms = lcdw_pkg::WAIT_STROBE;
        end
        lcdw_pkg::PH_EN_LOW: begin
          expander.expander_byte = {nibble, plan.bl, 1'b0, 1'b0, cur_rs};
          expander.wait_after_ms = nib ? cur_wait : lcdw_pkg::WAIT_STROBE;
        end
        default: begin
          expander.expander_byte = {nibble, plan.bl, 1'b0, 1'b0, cur_rs};
          expander.wait_after_ms = lcdw_pkg::WAIT_NONE;
        end
      endcase
    end
  end

  assign expander.valid      = busy;
  assign expander.last       = is_last;
  assign expander.column_now = plan.col;
  assign expander.row_now    = plan.row;

  // Advance through phases, nibbles and LCD bytes; load the next plan
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      sel   <= 1'b0;
      nib   <= 1'b0;
      phase <= lcdw_pkg::PH_PLAIN;
    end else if (plan_take) begin
      busy  <= 1'b1;
      sel   <= 1'b0;
      nib   <= 1'b0;
      phase <= lcdw_pkg::PH_PLAIN;
    end else if (fire) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        case (phase)
          lcdw_pkg::PH_PLAIN:   phase <= lcdw_pkg::PH_EN_HIGH;
          lcdw_pkg::PH_EN_HIGH: phase <= lcdw_pkg::PH_EN_LOW;
          default: begin
            phase <= lcdw_pkg::PH_PLAIN;
            nib   <= !nib;
            if (nib) begin
              sel <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Hold the plan being sent
  always_ff @(posedge clk) begin
    if (plan_take) begin
      plan <= plan_in;
    end
  end

  // After the final byte the walk restarts or stops
  assert property (@(posedge clk) disable iff (rst)
    fire && is_last |=> !busy || (phase == lcdw_pkg::PH_PLAIN && !nib && !sel))
    else $error("walk did not restart after final byte");

  // A backlight byte never advances the walk
  assert property (@(posedge clk) disable iff (rst)
    busy && plan.single |-> (phase == lcdw_pkg::PH_PLAIN) && !nib && !sel)
    else $error("backlight byte walked nibbles");

  // The second LCD byte is reached only when the plan has one
  assert property (@(posedge clk) disable iff (rst)
    busy && sel |-> plan.two)
    else $error("second LCD byte without plan");

endmodule

// ===== hdl/char_lcd_cursor_nibble_writer_top.sv =====
// Top level of the character LCD cursor nibble writer.
// Depends on lcdw_pkg, lcdw_cmd_if, lcdw_byte_if, lcdw_decode and lcdw_serializer.
//
// Each display command (put character, set cursor, clear, home, backlight) is
// decoded into a registered byte plan while the cursor and backlight state
// update; commands are taken back to back whenever the plan register is free or
// being handed on. The serializer then sends one expander byte per cycle while
// the sink is ready: a backlight command makes 1 byte, an LCD byte makes 6
// (three per nibble, high nibble first), and a printable character that wraps
// makes 12. The output port carries a single byte, so a command's bytes go out
// one after another; the serializer takes the next plan as it sends the last
// byte of the current one. Backspace at home and unused codes make no bytes.
// Each byte carries its wait hint, a last flag and the cursor position after
// the command.
module char_lcd_cursor_nibble_writer_top #(
  parameter int COLUMNS = lcdw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = lcdw_pkg::ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  lcdw_cmd_if.sink    commands,
  lcdw_byte_if.source expander
);

  lcdw_pkg::lcdw_plan_t plan;
  logic                 plan_valid;
  logic                 plan_take;

  // Decode commands and track the cursor
  lcdw_decode #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .commands   (commands),
    .plan       (plan),
    .plan_valid (plan_valid),
    .plan_take  (plan_take)
  );

  // Send the plan out as expander bytes
  lcdw_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .plan_in    (plan),
    .plan_valid (plan_valid),
    .plan_take  (plan_take),
    .expander   (expander)
  );

endmodule
